// File: rtl/es_pkg.sv
// es_pkg: shared types, register indexes and width helpers for element_sorter.
// Depends on nothing; imported by every module of the sorter except es_ram.
package es_pkg;

    localparam int DATA_W           = 64;
    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int CFG_ADDR_W       = 1;
    localparam int CFG_DATA_W       = 2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH_MODE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIGNED     = 1'd1;

    // element width codes
    localparam logic [1:0] WM_8  = 2'd0;
    localparam logic [1:0] WM_16 = 2'd1;
    localparam logic [1:0] WM_32 = 2'd2;
    localparam logic [1:0] WM_64 = 2'd3;

    typedef struct packed {
        logic [1:0] width_mode;
        logic       signed_cmp;
    } t_cmp_cfg;

    function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] mode);
        logic [DATA_W-1:0] m;
        unique case (mode)
            WM_8:    m = 64'h0000_0000_0000_00FF;
            WM_16:   m = 64'h0000_0000_0000_FFFF;
            WM_32:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] sign_bit(input logic [1:0] mode);
        logic [DATA_W-1:0] s;
        unique case (mode)
            WM_8:    s = 64'h0000_0000_0000_0080;
            WM_16:   s = 64'h0000_0000_0000_8000;
            WM_32:   s = 64'h0000_0000_8000_0000;
            default: s = 64'h8000_0000_0000_0000;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/es_ram.sv
// es_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module es_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/es_cmp.sv
// es_cmp: shared compare unit; masks a stored element, forms its sort key and
// decides whether it is the new running minimum above the last emitted one.
// Depends on es_pkg.
module es_cmp
    import es_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  t_cmp_cfg          i_cfg,
    input  logic [DATA_W-1:0] i_raw,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic              i_has_prev,
    input  logic [DATA_W-1:0] i_prev_key,
    input  logic [IDX_W-1:0]  i_prev_idx,
    input  logic              i_has_best,
    input  logic [DATA_W-1:0] i_best_key,
    input  logic [IDX_W-1:0]  i_best_idx,
    output logic [DATA_W-1:0] o_val,
    output logic [DATA_W-1:0] o_key,
    output logic              o_take
);
    logic [DATA_W+IDX_W-1:0] cand_tag;
    logic                    above_prev;
    logic                    below_best;

    // ties are broken by store index so equal keys are each emitted once
    always_comb begin
        o_val      = i_raw & width_mask(i_cfg.width_mode);
        o_key      = i_cfg.signed_cmp ? (o_val ^ sign_bit(i_cfg.width_mode)) : o_val;
        cand_tag   = {o_key, i_idx};
        above_prev = !i_has_prev || (cand_tag > {i_prev_key, i_prev_idx});
        below_best = !i_has_best || (cand_tag < {i_best_key, i_best_idx});
        o_take     = above_prev && below_best;
    end
endmodule

// File: rtl/element_sorter.sv
// element_sorter: collects up to MAX_ELEMENTS elements and emits them sorted.
// Load: one element per cycle, s_axis_tready high in the load phase only.
// Sort: each result needs one pass over the n stored elements through the
//   single RAM read port and shared comparator, plus the output handshake.
// Reset (i_rst_n low, synchronous): empty store, width 64, unsigned compare.
module element_sorter
    import es_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input element stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,   // [63:0] element_value
    input  logic                  s_axis_tlast,   // last_in_set
    // sorted output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [63:0]           m_axis_tdata,   // [63:0] sorted_value
    output logic                  m_axis_tlast,   // last_out
    output logic                  m_axis_tuser    // [0] overflowed
);
    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state            r_state;
    t_cmp_cfg          r_cfg;

    // load side
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_n;

    // scan pass
    logic [CNT_W-1:0]  r_issue;     // next store address to read
    logic              r_rd_valid;  // RAM data of r_rd_idx arrives this cycle
    logic [IDX_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  r_emitted;

    // last emitted element and running minimum of this pass
    logic              r_has_prev;
    logic [DATA_W-1:0] r_prev_key;
    logic [IDX_W-1:0]  r_prev_idx;
    logic              r_has_best;
    logic [DATA_W-1:0] r_best_key;
    logic [IDX_W-1:0]  r_best_idx;
    logic [DATA_W-1:0] r_best_val;

    // output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;
    logic              r_out_ovf;

    logic              in_req;
    logic              out_req;
    logic              store_ok;
    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] cmp_val;
    logic [DATA_W-1:0] cmp_key;
    logic              cmp_take;
    logic              issue;
    logic [CNT_W-1:0]  n_count;

    assign s_axis_tready = (r_state == S_LOAD);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign out_req       = r_out_valid && m_axis_tready;
    assign store_ok      = (r_count < CNT_MAX);
    assign ram_we        = in_req && store_ok;
    assign n_count       = store_ok ? (r_count + CNT_ONE) : r_count;
    assign issue         = (r_state == S_SCAN) && (r_issue < r_n);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ovf;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_mode <= WM_64;
            r_cfg.signed_cmp <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WIDTH_MODE: r_cfg.width_mode <= i_cfg_wdata;
                CFG_SIGNED:     r_cfg.signed_cmp <= i_cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    es_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_issue[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    es_cmp #(
        .IDX_W (IDX_W)
    ) u_cmp (
        .i_cfg      (r_cfg),
        .i_raw      (ram_rdata),
        .i_idx      (r_rd_idx),
        .i_has_prev (r_has_prev),
        .i_prev_key (r_prev_key),
        .i_prev_idx (r_prev_idx),
        .i_has_best (r_has_best),
        .i_best_key (r_best_key),
        .i_best_idx (r_best_idx),
        .o_val      (cmp_val),
        .o_key      (cmp_key),
        .o_take     (cmp_take)
    );

    // sequencer: load, then per result one selection pass and one emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_n         <= '0;
            r_issue     <= '0;
            r_rd_valid  <= 1'b0;
            r_emitted   <= '0;
            r_has_prev  <= 1'b0;
            r_has_best  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= issue;
            if (issue) begin
                r_rd_idx <= r_issue[IDX_W-1:0];
                r_issue  <= r_issue + CNT_ONE;
            end
            if (r_rd_valid && cmp_take) begin
                r_has_best <= 1'b1;
                r_best_key <= cmp_key;
                r_best_idx <= r_rd_idx;
                r_best_val <= cmp_val;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (in_req) begin
                        r_count <= n_count;
                        if (!store_ok) begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_n        <= n_count;
                            r_issue    <= '0;
                            r_emitted  <= '0;
                            r_has_prev <= 1'b0;
                            r_has_best <= 1'b0;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // pass ends once every address is read and compared
                    if (!issue && !r_rd_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_best_val;
                        r_out_last  <= (r_emitted + CNT_ONE == r_n);
                        r_out_ovf   <= r_ovf;
                        r_has_prev  <= 1'b1;
                        r_prev_key  <= r_best_key;
                        r_prev_idx  <= r_best_idx;
                        r_emitted   <= r_emitted + CNT_ONE;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_req) begin
                        r_out_valid <= 1'b0;
                        r_has_best  <= 1'b0;
                        r_issue     <= '0;
                        if (r_out_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

// File: rtl/es_checker.sv
// es_checker: port-level assertions for element_sorter, bound to the top level.
// Depends on es_pkg for widths.
module es_checker
    import es_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);
    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // the last request of a set closes the input until sorting is done
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input ready right after the last element");

    // after the final result the block loads again
    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (s_axis_tready && !m_axis_tvalid))
        else $error("no return to loading after final result");
endmodule

bind element_sorter es_checker u_es_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb.sv
// tb: self-checking testbench for element_sorter (load a set, read it back sorted).
// Depends on es_pkg, element_sorter and its submodules es_ram and es_cmp.
`timescale 1ns / 100ps

module tb;
    import es_pkg::*;

    localparam int CAPACITY       = MAX_ELEMENTS_DEF;
    // settling margin after the drain, for any sort still in flight
    localparam int SETTLE_CYCLES  = 2 * CAPACITY + 8;
    // no request for this long means the DUT is stuck
    localparam int WATCHDOG_LIMIT = 20000;
    // small-set items in the random part; the overflow set comes on top
    localparam int SMALL_ITEMS    = 24;

    typedef enum int {
        IDLE_SEND_LIGHT,   // sender idles 20%, receiver 72%
        IDLE_SEND_HEAVY,   // sender idles 72%, receiver 20%
        IDLE_NONE          // both sides at full rate
    } t_idle_plan;

    typedef struct {
        logic [63:0] value;
        logic        last;
    } t_element_req;

    typedef struct {
        logic [63:0] value;
        logic        last;
        logic        ovf;
    } t_sorted_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;   // [63:0] element_value
    logic                  s_axis_tlast  = 1'b0; // last_in_set
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;         // [63:0] sorted_value
    logic                  m_axis_tlast;         // last_out
    logic                  m_axis_tuser;         // [0] overflowed

    t_element_req   pending_elems[$];
    t_sorted_result sorted_expected[$];
    t_element_req   next_req;
    t_sorted_result want;

    // shadow of the DUT state and registers
    logic [63:0] set_buf[CAPACITY];
    int          set_len      = 0;
    logic        set_dropped  = 1'b0;
    logic [1:0]  shadow_width = WM_64;
    logic        shadow_signed = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int stall_cycles  = 0;

    element_sorter #(
        .MAX_ELEMENTS (CAPACITY)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Element predictor. Stores raw bits; width and signedness are applied only
    // when the set closes, so a set is sorted with the registers as they stand then.
    function automatic void accept_element(input logic [63:0] value, input logic last);
        logic [63:0]    ord[CAPACITY];
        logic [63:0]    mask;
        logic [63:0]    flip;
        logic [63:0]    v;
        int             lane_bits;
        int             j;
        t_sorted_result r;
        if (set_len < CAPACITY) begin
            set_buf[set_len] = value;
            set_len++;
        end else begin
            set_dropped = 1'b1;   // full store: element lost, even a flagged last one
        end
        if (!last) return;

        lane_bits = 8 << shadow_width;
        mask      = (lane_bits == 64) ? '1 : (64'd1 << lane_bits) - 64'd1;
        // xor with the sign bit turns a two's complement order into an unsigned one
        flip      = shadow_signed ? (64'd1 << (lane_bits - 1)) : 64'd0;

        for (int i = 0; i < set_len; i++) begin
            v = set_buf[i] & mask;
            j = i;
            while (j > 0 && (ord[j-1] ^ flip) > (v ^ flip)) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = v;
        end
        for (int i = 0; i < set_len; i++) begin
            r.value = ord[i];
            r.last  = (i == set_len - 1);
            r.ovf   = set_dropped;
            sorted_expected.push_back(r);
        end
        set_len     = 0;
        set_dropped = 1'b0;
    endfunction

    // Input driver: one NBA per signal per edge; valid held until the request is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                accept_element(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_elems.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    next_req = pending_elems.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_req.value;
                    s_axis_tlast  <= next_req.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compares each result request with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (sorted_expected.size() == 0) begin
                    $error("unexpected result: sorted_value %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = sorted_expected.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $error("sorted_value: expected %h, got %h", want.value, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_out: expected %b, got %b", want.last, m_axis_tlast);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.ovf) begin
                        $error("overflowed: expected %b, got %b", want.ovf, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run after too long without any request on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_WIDTH_MODE)
            shadow_width = val;
        else
            shadow_signed = val[0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void set_idling(input t_idle_plan plan);
        case (plan)
            IDLE_SEND_LIGHT: begin
                send_idle_pct = 20;
                recv_idle_pct = 72;
            end
            IDLE_SEND_HEAVY: begin
                send_idle_pct = 72;
                recv_idle_pct = 20;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endfunction

    function automatic void push_element(input logic [63:0] value, input logic last);
        t_element_req req;
        req.value = value;
        req.last  = last;
        pending_elems.push_back(req);
    endfunction

    function automatic logic [63:0] pick_element();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7, 0))
            0: v[7:0] = 8'($urandom_range(3, 0));   // crowd the low byte: ties at 8 bits
            1: v[15:0] = 16'($urandom_range(1, 0) ? 16'h8000 : 16'h7FFF);
            default: ;
        endcase
        return v;
    endfunction

    function automatic void queue_set(input int n);
        for (int i = 0; i < n; i++)
            push_element(pick_element(), i == n - 1);
    endfunction

    // Sender holds off until the DUT has drained, then lets any sort finish.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_elems.size() != 0 || s_axis_tvalid || sorted_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int  small_items;
        int  nsets;
        int  set_size;
        bit  big_done;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes at 64 bits unsigned, plus a one-element set
        set_idling(IDLE_SEND_LIGHT);
        write_reg(CFG_WIDTH_MODE, WM_64);
        write_reg(CFG_SIGNED, 2'd0);
        push_element(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_element(64'h0000_0000_0000_0000, 1'b0);
        push_element(64'h8000_0000_0000_0000, 1'b0);
        push_element(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        push_element(64'h0000_0000_0000_0001, 1'b1);
        push_element(64'h0000_0000_0000_1234, 1'b1);
        wait_drained();

        // same extremes, two's complement order
        write_reg(CFG_SIGNED, 2'd1);
        push_element(64'h8000_0000_0000_0000, 1'b0);
        push_element(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        push_element(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_element(64'h0000_0000_0000_0000, 1'b1);
        wait_drained();

        // 8-bit signed: upper bits ignored, equal elements
        write_reg(CFG_WIDTH_MODE, WM_8);
        push_element(64'hA5A5_A5A5_A5A5_A57F, 1'b0);
        push_element(64'h0000_0000_0000_0080, 1'b0);
        push_element(64'h0000_0000_0000_00FF, 1'b0);
        push_element(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_element(64'h1234_5678_9ABC_DE00, 1'b1);
        wait_drained();

        // 16-bit unsigned
        write_reg(CFG_WIDTH_MODE, WM_16);
        write_reg(CFG_SIGNED, 2'd0);
        push_element(64'h0000_0000_0000_FFFF, 1'b0);
        push_element(64'h0000_0000_0000_0000, 1'b0);
        push_element(64'hDEAD_BEEF_0001_8000, 1'b0);
        push_element(64'h0000_0000_0000_7FFF, 1'b1);
        wait_drained();

        // 32-bit signed
        write_reg(CFG_WIDTH_MODE, WM_32);
        write_reg(CFG_SIGNED, 2'd1);
        push_element(64'h0000_0000_8000_0000, 1'b0);
        push_element(64'h0000_0000_7FFF_FFFF, 1'b0);
        push_element(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_element(64'h0000_0001_0000_0000, 1'b1);
        wait_drained();

        // random: mostly small sets under random settings, one set past capacity
        small_items = 0;
        big_done    = 1'b0;
        while (small_items < SMALL_ITEMS) begin
            if (small_items < SMALL_ITEMS / 3)
                set_idling(IDLE_SEND_LIGHT);
            else if (small_items < 2 * SMALL_ITEMS / 3)
                set_idling(IDLE_SEND_HEAVY);
            else
                set_idling(IDLE_NONE);
            write_reg(CFG_WIDTH_MODE, 2'($urandom_range(3, 0)));
            write_reg(CFG_SIGNED, 2'($urandom_range(1, 0)));
            nsets = $urandom_range(3, 1);
            for (int s = 0; s < nsets; s++) begin
                if (!big_done && small_items >= SMALL_ITEMS / 3) begin
                    // fills the store, then drops two more, the flagged last among them
                    queue_set(CAPACITY + 2);
                    big_done = 1'b1;
                end else begin
                    set_size = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 7)
                                                           : $urandom_range(6, 1);
                    queue_set(set_size);
                    small_items += set_size;
                end
            end
            wait_drained();
        end

        if (mismatches == 0 && sorted_expected.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
